### hdl/hcca_pkg.sv
// ---------------------------------------------------------------------------
// hcca_pkg: shared codes for the hit cluster centroid accumulator
// Status codes reported with every result word.
// ---------------------------------------------------------------------------
`default_nettype none
package hcca_pkg;
    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

### hdl/hcca_div.sv
// ---------------------------------------------------------------------------
// hcca_div: signed radix-2 restoring divider
// One quotient bit per cycle, quotient truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none
module hcca_div #(
    parameter int W = 48
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,   // signed
    input  wire logic [W-1:0] divisor,    // positive
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W-1:0]  mag;

    assign mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;

    always_comb begin
        trial  = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
        q_next = {q_reg[W-2:0], 1'b0};
        r_next = {r_reg[W-1:0], q_reg[W-1]};
        if (!trial[W]) begin
            r_next    = trial;
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse on the last quotient bit
            done_reg <= busy_reg && !start && cnt_reg == CW'(1);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                q_reg    <= mag;
                r_reg    <= '0;
                d_reg    <= divisor;
                neg_reg  <= dividend[W-1];
            end else if (busy_reg) begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + W'(1)) : q_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without work");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |=> busy_reg || done_reg) else $error("divider lost");
    a_cnt_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
`endif
endmodule
`default_nettype wire

### hdl/hit_cluster_centroid_accumulator_top.sv
// Hit cluster centroid accumulator. One result word per hit. From its accept
// to the next possible accept a hit occupies the block with six divisions on
// the one shared radix-2 divider, the duplicate search that walks the id store
// one member per cycle, the weighted products of the three axes when the hit
// is added, and the load of the result word. The result word waits in its own
// register, so the next hit is taken while it is held; only a second finished
// word stalls until the first one is accepted.
// ---------------------------------------------------------------------------
// hit_cluster_centroid_accumulator_top
// Accumulates sums per cluster and reports span, means and pulse stats.
// ---------------------------------------------------------------------------
`default_nettype none
module hit_cluster_centroid_accumulator_top #(
    parameter int MAX_HITS   = 16,
    parameter int POS_BITS   = 24,
    parameter int PULSE_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: hit_id, strip, pos_x, pos_y, pos_z, pulse (low bit up)
    input  wire logic [8*((24+3*POS_BITS+PULSE_BITS+7)/8)-1:0] s_tdata,
    // tuser: start_new
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: status, cluster_size, first_strip, last_strip, mean_x/y/z,
    // weighted_x/y/z, pulse_total, pulse_peak (low bit up)
    output logic [8*((59+6*POS_BITS+7)/8)-1:0] m_tdata
);
    localparam int IW  = 8*((24+3*POS_BITS+PULSE_BITS+7)/8);
    localparam int OW  = 8*((59+6*POS_BITS+7)/8);
    localparam int PB  = POS_BITS;
    localparam int SW  = PB + 8;
    localparam int WW  = PB + PULSE_BITS + 8;
    localparam int DW  = WW + 1;
    localparam int CW  = $clog2(MAX_HITS + 1);
    localparam int AW  = $clog2(MAX_HITS);
    localparam int PW  = PB + PULSE_BITS;
    localparam int QW  = PULSE_BITS + $clog2(MAX_HITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SRCH = 5'b00010, S_MUL = 5'b00100,
        S_DIV = 5'b01000, S_OUT = 5'b10000
    } state_t;
    state_t state_reg;

    logic [15:0] mem [MAX_HITS];
    logic [15:0] rd_reg;
    logic [IW-1:0] in_reg;
    logic start_reg, dup_reg;
    logic [CW-1:0] cnt_reg, idx_reg;
    logic [7:0] lo_reg, hi_reg;
    logic [SW-1:0] psum_reg [3];
    logic [WW-1:0] wsum_reg [3];
    logic [QW-1:0] pls_reg;
    logic [PULSE_BITS-1:0] pmax_reg;
    logic [2:0] k_reg;
    logic [1:0] st_reg;
    logic [PB-1:0] res_reg [6];
    logic [PW-1:0] prod_reg;
    logic [OW-1:0] out_reg;

    logic [15:0] id_in;
    logic [7:0] strip_in;
    logic [PB-1:0] pos_in [3];
    logic [PULSE_BITS-1:0] pulse_in;
    assign id_in    = in_reg[15:0];
    assign strip_in = in_reg[23:16];
    assign pos_in[0] = in_reg[24 +: PB];
    assign pos_in[1] = in_reg[24+PB +: PB];
    assign pos_in[2] = in_reg[24+2*PB +: PB];
    assign pulse_in = in_reg[24+3*PB +: PULSE_BITS];

    // divider operands chosen by step k: 0..2 plain, 3..5 weighted (plain when the pulse total is zero)
    logic div_start_reg, div_done;
    logic [DW-1:0] dvd, dvs, quo;
    logic [1:0] ax;
    assign ax = (k_reg >= 3'd3) ? 2'(k_reg - 3'd3) : k_reg[1:0];
    always_comb begin
        if (k_reg < 3'd3 || pls_reg == '0) begin
            dvd = DW'($signed(psum_reg[ax]));
            dvs = DW'(cnt_reg);
        end else begin
            dvd = DW'($signed(wsum_reg[ax]));
            dvs = DW'(pls_reg);
        end
    end

    hcca_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(dvd), .divisor(dvs), .done(div_done), .quotient(quo)
    );

    logic new_clu;
    assign new_clu = start_reg || cnt_reg == '0;
    assign s_tready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_reg <= s_tdata;
        rd_reg <= mem[idx_reg[AW-1:0]];
        if (state_reg == S_MUL)
            prod_reg <= PW'($signed(pos_in[ax])) * PW'($signed({1'b0, pulse_in}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid  <= 1'b0;
            cnt_reg   <= '0;
            lo_reg <= '0; hi_reg <= '0; pls_reg <= '0; pmax_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                psum_reg[i] <= '0; wsum_reg[i] <= '0;
            end
            div_start_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && !m_tvalid) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    start_reg <= s_tuser;
                    idx_reg   <= '0;
                    dup_reg   <= 1'b0;
                    state_reg <= S_SRCH;
                end
                S_SRCH: begin
                    // rd_reg holds the entry addressed in the cycle before
                    if (new_clu) begin
                        st_reg <= hcca_pkg::ST_ADDED;
                        mem[0] <= id_in;
                        cnt_reg <= CW'(1);
                        lo_reg <= strip_in; hi_reg <= strip_in;
                        pls_reg <= QW'(pulse_in); pmax_reg <= pulse_in;
                        for (int i = 0; i < 3; i++) begin
                            psum_reg[i] <= SW'($signed(pos_in[i]));
                            wsum_reg[i] <= '0;
                        end
                        k_reg <= '0;
                        state_reg <= S_MUL;
                    end else if (idx_reg != '0 && rd_reg == id_in && !dup_reg) begin
                        dup_reg <= 1'b1;
                    end else if (idx_reg < cnt_reg && !dup_reg) begin
                        idx_reg <= idx_reg + CW'(1);
                    end else begin
                        idx_reg <= idx_reg;
                        k_reg <= '0;
                        if (dup_reg) begin
                            st_reg <= hcca_pkg::ST_DUP;
                            div_start_reg <= 1'b1; state_reg <= S_DIV;
                        end else if (cnt_reg >= CW'(MAX_HITS)) begin
                            st_reg <= hcca_pkg::ST_FULL;
                            div_start_reg <= 1'b1; state_reg <= S_DIV;
                        end else begin
                            st_reg <= hcca_pkg::ST_ADDED;
                            mem[cnt_reg[AW-1:0]] <= id_in;
                            cnt_reg <= cnt_reg + CW'(1);
                            if (strip_in < lo_reg) lo_reg <= strip_in;
                            if (strip_in > hi_reg) hi_reg <= strip_in;
                            pls_reg <= pls_reg + QW'(pulse_in);
                            if (pulse_in > pmax_reg) pmax_reg <= pulse_in;
                            for (int i = 0; i < 3; i++)
                                psum_reg[i] <= psum_reg[i] + SW'($signed(pos_in[i]));
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // one product per visit; accumulate on the next
                    if (k_reg != '0)
                        wsum_reg[2'(k_reg - 3'd1)] <= wsum_reg[2'(k_reg - 3'd1)] +
                            WW'($signed(prod_reg));
                    if (k_reg == 3'd3) begin
                        k_reg <= '0; div_start_reg <= 1'b1; state_reg <= S_DIV;
                    end else k_reg <= k_reg + 3'd1;
                end
                S_DIV: begin
                    div_start_reg <= div_done && k_reg != 3'd5;
                    if (div_done) begin
                        res_reg[k_reg] <= quo[PB-1:0];
                        if (k_reg == 3'd5) state_reg <= S_OUT;
                        else k_reg <= k_reg + 3'd1;
                    end
                end
                S_OUT: if (!m_tvalid) begin
                    // hold here until the previous word has left
                    out_reg <= OW'({16'(pmax_reg), 20'(pls_reg), res_reg[5],
                        res_reg[4], res_reg[3], res_reg[2], res_reg[1], res_reg[0],
                        hi_reg, lo_reg, 5'(cnt_reg), st_reg});
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("accept while busy");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_HITS)) else $error("count overflow");
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_reg <= hi_reg) else $error("strip span inverted");
`endif
endmodule
`default_nettype wire
